@@ rtl/core/qbf_pkg.sv @@
// Shared types and constants of the quadratic Bezier flattener.
package qbf_pkg;

    // Width of every coordinate field on the ports.
    localparam int FIELD_W = 32;

    // Width and reset value of the flatness tolerance register.
    localparam int TOL_W = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd65536;

    // Default subdivision cap and internal coordinate width.
    localparam int MAX_DEPTH_DEF = 6;
    localparam int COORD_BITS_DEF = 32;

    // One curve to be flattened.
    typedef struct packed {
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] ctrl_x;
        logic signed [FIELD_W-1:0] ctrl_y;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] end_y;
    } curve_in_t;

    // One polyline vertex.
    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic                      last_point;
    } point_out_t;

endpackage

@@ rtl/core/quad_bezier_flattener_unit.sv @@
// Top level of the quadratic Bezier flattener: sequencer, datapath and stack.
//
// The unit takes one quadratic Bezier curve (start, control and end points in
// signed Q16.16) when start is high and busy is low, and flattens it by
// depth-first midpoint subdivision. Each flat segment yields its end point as
// one result item, shown for exactly one cycle with point_strobe high; the
// final vertex of a curve carries last_point. The receiver cannot hold items
// off, so it must take every strobed item. The curve start point is never
// emitted. A segment is flat when the L1 distance between its control point
// and the midpoint of its chord is at most the tolerance register, and a
// segment at MAX_DEPTH subdivisions is emitted without a test, so one curve
// gives at most 2^MAX_DEPTH vertices. Each segment visited passes through an
// evaluation state, which forms the deviation and the half-curve midpoints,
// and a decision state, which either emits or pushes; each return to a
// deferred half passes through a further state for the read of the stack
// memory. The rate is set by this one shared evaluation unit and the single
// read port of the stack memory. busy falls in the same cycle that the last
// vertex appears on the result ports; a new curve may be given while that
// vertex is still on the result ports. The tolerance register may be written
// only while busy is low and no vertex is pending.
module quad_bezier_flattener_unit #(
    parameter int MAX_DEPTH  = qbf_pkg::MAX_DEPTH_DEF,
    parameter int COORD_BITS = qbf_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Curve input
    input  logic                        start,
    output logic                        busy,
    input  qbf_pkg::curve_in_t          curve,
    // Tolerance register
    input  logic                        cfg_we,
    input  logic [qbf_pkg::TOL_W-1:0]   cfg_wdata,
    // Vertex output
    output logic                        point_strobe,
    output qbf_pkg::point_out_t         point
);

    localparam int CB       = COORD_BITS;
    localparam int FW       = qbf_pkg::FIELD_W;
    localparam int TW       = qbf_pkg::TOL_W;
    // The stack holds one deferred half per level, plus one spare entry.
    localparam int STACK_D  = MAX_DEPTH + 1;
    localparam int ADDR_W   = (STACK_D > 1) ? $clog2(STACK_D) : 1;
    localparam int LVL_W    = $clog2(MAX_DEPTH + 1);
    localparam int ENTRY_W  = 4 * CB + LVL_W;
    // Deviation magnitudes need CB+2 bits; the compare runs at the wider of
    // that and the tolerance width.
    localparam int DEV_W    = CB + 2;
    localparam int CMP_W    = (DEV_W > TW) ? DEV_W : TW;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_POP    = 4'b1000
    } state_t;

    // Floor of the mean of two coordinates; the mean always lies between
    // its operands, so it fits the coordinate width again.
    function automatic logic signed [CB-1:0] mid_coord(
        input logic signed [CB-1:0] a,
        input logic signed [CB-1:0] b
    );
        logic signed [CB:0] sum;
        sum = (CB+1)'(a) + (CB+1)'(b);
        return sum[CB:1];
    endfunction

    // Magnitude of a signed difference, as an unsigned value.
    function automatic logic [CB:0] magnitude(input logic signed [CB:0] v);
        return v[CB] ? (~v + 1'b1) : v;
    endfunction

    state_t                 state_reg, state_next;
    logic [TW-1:0]          tol_reg, tol_next;

    // Segment in work.
    logic signed [CB-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CB-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CB-1:0]   ex_reg, ex_next, ey_reg, ey_next;
    logic [LVL_W-1:0]       level_reg, level_next;
    logic [ADDR_W-1:0]      top_reg, top_next;

    // Results of the evaluation cycle.
    logic signed [CB:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic signed [CB-1:0]   cbx_reg, cbx_next, cby_reg, cby_next;
    logic signed [CB-1:0]   cex_reg, cex_next, cey_reg, cey_next;

    // Output register.
    logic                   strobe_reg, strobe_next;
    qbf_pkg::point_out_t    point_reg, point_next;

    // Stack memory port.
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

    // Decision logic.
    logic signed [CB-1:0]   chord_mx, chord_my;
    logic signed [CB-1:0]   p0x, p0y;
    logic [DEV_W-1:0]       dev;
    logic                   flat, leaf;

    qbf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_D)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        chord_mx = mid_coord(sx_reg, ex_reg);
        chord_my = mid_coord(sy_reg, ey_reg);
        p0x      = mid_coord(cbx_reg, cex_reg);
        p0y      = mid_coord(cby_reg, cey_reg);
        dev      = DEV_W'(magnitude(dx_reg)) + DEV_W'(magnitude(dy_reg));
        flat     = CMP_W'(dev) <= CMP_W'(tol_reg);
        leaf     = flat || (level_reg == LVL_W'(MAX_DEPTH));
    end

    always_comb
    begin
        state_next  = state_reg;
        tol_next    = tol_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        level_next  = level_reg;
        top_next    = top_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        cbx_next    = cbx_reg;
        cby_next    = cby_reg;
        cex_next    = cex_reg;
        cey_next    = cey_reg;
        strobe_next = 1'b0;
        point_next  = point_reg;
        ram_we      = 1'b0;
        ram_waddr   = top_reg;
        ram_wdata   = {cex_reg, cey_reg, ex_reg, ey_reg, level_reg + 1'b1};
        ram_raddr   = top_reg - 1'b1;

        if (cfg_we)
        begin
            tol_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Only the low COORD_BITS of each field take part.
                    sx_next    = curve.start_x[CB-1:0];
                    sy_next    = curve.start_y[CB-1:0];
                    cx_next    = curve.ctrl_x[CB-1:0];
                    cy_next    = curve.ctrl_y[CB-1:0];
                    ex_next    = curve.end_x[CB-1:0];
                    ey_next    = curve.end_y[CB-1:0];
                    level_next = '0;
                    top_next   = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                dx_next    = (CB+1)'(cx_reg) - (CB+1)'(chord_mx);
                dy_next    = (CB+1)'(cy_reg) - (CB+1)'(chord_my);
                cbx_next   = mid_coord(sx_reg, cx_reg);
                cby_next   = mid_coord(sy_reg, cy_reg);
                cex_next   = mid_coord(cx_reg, ex_reg);
                cey_next   = mid_coord(cy_reg, ey_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (leaf)
                begin
                    strobe_next           = 1'b1;
                    point_next.point_x    = FW'(ex_reg);
                    point_next.point_y    = FW'(ey_reg);
                    point_next.last_point = (top_reg == '0);
                    if (top_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Resume with the most recent deferred second half.
                        sx_next    = ex_reg;
                        sy_next    = ey_reg;
                        top_next   = top_reg - 1'b1;
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    // Defer the second half and carry on with the first.
                    ram_we     = 1'b1;
                    top_next   = top_reg + 1'b1;
                    cx_next    = cbx_reg;
                    cy_next    = cby_reg;
                    ex_next    = p0x;
                    ey_next    = p0y;
                    level_next = level_reg + 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_POP:
            begin
                cx_next    = ram_rdata[4*CB+LVL_W-1 -: CB];
                cy_next    = ram_rdata[3*CB+LVL_W-1 -: CB];
                ex_next    = ram_rdata[2*CB+LVL_W-1 -: CB];
                ey_next    = ram_rdata[CB+LVL_W-1 -: CB];
                level_next = ram_rdata[LVL_W-1:0];
                state_next = ST_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tol_reg    <= qbf_pkg::TOL_RESET;
            strobe_reg <= 1'b0;
            top_reg    <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tol_reg    <= tol_next;
            strobe_reg <= strobe_next;
            top_reg    <= top_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        level_reg <= level_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        cbx_reg   <= cbx_next;
        cby_reg   <= cby_next;
        cex_reg   <= cex_next;
        cey_reg   <= cey_next;
        point_reg <= point_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign point_strobe = strobe_reg;
    assign point        = point_reg;

endmodule

@@ rtl/core/qbf_ram.sv @@
// Generic single-port-write, registered-read RAM.
module qbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
